FILE: design/wiep_pkg.sv
// Package for the WLAN information element parser.
// Holds element ids, vendor OUI bytes, the parse phase type and the result types.
// No dependencies; imported by the parser top level and its checker.
package wiep_pkg;

   localparam logic [7:0] ID_SSID   = 8'd0;
   localparam logic [7:0] ID_DSSS   = 8'd3;
   localparam logic [7:0] ID_RSN    = 8'd48;
   localparam logic [7:0] ID_VENDOR = 8'd221;

   localparam logic [7:0] OUI_BYTE0 = 8'h00;
   localparam logic [7:0] OUI_BYTE1 = 8'h50;
   localparam logic [7:0] OUI_BYTE2 = 8'hF2;
   localparam logic [7:0] WPA_TYPE  = 8'h01;

   localparam logic [11:0] MIN_ELEMENT_BYTES = 12'd2;

   localparam int FLAG_SSID = 0;
   localparam int FLAG_CHAN = 1;
   localparam int FLAG_RSN  = 2;
   localparam int FLAG_WPA  = 3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_BYTE  = 1'b1;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [3:0] {
      PH_ID   = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_BODY = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       wpa_seen;
      logic       rsn_seen;
      logic       ssid_seen;
      logic       channel_seen;
      logic [7:0] channel_number;
      logic [5:0] ssid_length;
      logic [7:0] ssid_char;
      logic [5:0] ssid_position;
   } rsp_data_type;

   typedef struct packed {
      logic         kind;
      logic         last;
      rsp_data_type data;
   } rsp_entry_type;

endpackage

FILE: design/wlan_information_element_parser_unit.sv
// WLAN information element parser, top level.
// Depends on wiep_pkg for element ids, phase codes and result types.
//
// Usage:
//   The req_ channel carries one transfer per item. A start transfer (req_tuser 0)
//   arms the parser with a region byte count in req_tdata[11:0]; a byte transfer
//   (req_tuser 1) delivers one region byte in req_tdata[19:12].
//   The rsp_ channel returns SSID characters (rsp_tuser 0) and, on the last byte
//   of a region or on an empty region, a summary (rsp_tuser 1). rsp_tlast marks
//   the final result caused by one input transfer.
//   Results enter a four-entry result queue and are offered once earlier ones drain.
//   Throughput is one item per cycle while req_tready is high; the state update
//   is a single pass of logic from the state registers into that queue.
//   An item that causes two results adds one entry of backlog, so req_tready
//   drops only when the queue holds more than two entries.
//   Reset clears the parser state and empties the queue; the parser then waits
//   for a start transfer and ignores byte transfers. When the receiver stalls,
//   the queue fills and req_tready goes low until entries drain.
module wlan_information_element_parser_unit
   import wiep_pkg::*;
#(
   parameter int SSID_STORE_BYTES = 34
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // region_length[11:0], data_byte[19:12], zero pad
   input  logic        req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // ssid_position[5:0], ssid_char[13:6],
                                   // ssid_length[19:14], channel_number[27:20],
                                   // channel_seen[28], ssid_seen[29], rsn_seen[30],
                                   // wpa_seen[31]
   output logic        rsp_tuser,  // result_kind
   output logic        rsp_tlast   // last_of_run
);

   localparam logic [8:0] SsidLimit = 9'(SSID_STORE_BYTES - 1);
   localparam int QueueDepth = 4;
   localparam int PtrBits = $clog2(QueueDepth);

   logic [11:0] bytes_left_ff, bytes_left_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  element_id_ff, element_id_in;
   logic [7:0]  element_length_ff, element_length_in;
   logic [7:0]  body_offset_ff, body_offset_in;
   logic        oui_match_ff, oui_match_in;
   logic [5:0]  ssid_length_ff, ssid_length_in;
   logic [7:0]  channel_ff, channel_in;
   logic [3:0]  flags_ff, flags_in;

   logic [11:0] region_length;
   logic [7:0]  data_byte;
   logic [7:0]  offset_inc;
   logic        req_xfer;
   logic        rsp_xfer;
   logic        ssid_emit;
   logic        summ_emit;

   rsp_entry_type ssid_entry;
   rsp_entry_type summ_entry;
   rsp_entry_type push0;
   rsp_entry_type push1;
   logic [1:0]    push_cnt;

   rsp_entry_type queue_mem [QueueDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_next1;
   logic [PtrBits:0]   count_ff, count_in;

   assign region_length = req_tdata[11:0];
   assign data_byte     = req_tdata[19:12];
   assign offset_inc    = body_offset_ff + 8'd1;
   assign req_tready    = count_ff <= (PtrBits+1)'(QueueDepth - 2);
   assign req_xfer      = req_tvalid && req_tready;
   assign rsp_tvalid    = count_ff != '0;
   assign rsp_xfer      = rsp_tvalid && rsp_tready;

   always_comb begin
      bytes_left_in     = bytes_left_ff;
      phase_in          = phase_ff;
      element_id_in     = element_id_ff;
      element_length_in = element_length_ff;
      body_offset_in    = body_offset_ff;
      oui_match_in      = oui_match_ff;
      ssid_length_in    = ssid_length_ff;
      channel_in        = channel_ff;
      flags_in          = flags_ff;
      ssid_emit         = 1'b0;
      summ_emit         = 1'b0;
      if (req_xfer) begin
         if (req_tuser == OP_START) begin
            element_id_in     = '0;
            element_length_in = '0;
            body_offset_in    = '0;
            oui_match_in      = 1'b0;
            ssid_length_in    = '0;
            channel_in        = '0;
            flags_in          = '0;
            bytes_left_in     = region_length;
            if (region_length == '0) begin
               phase_in  = PH_DONE;
               summ_emit = 1'b1;
            end else begin
               phase_in = PH_ID;
            end
         end else if (bytes_left_ff != '0) begin
            unique case (phase_ff)
               PH_ID: begin
                  if (bytes_left_ff > MIN_ELEMENT_BYTES) begin
                     element_id_in = data_byte;
                     phase_in      = PH_LEN;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               PH_LEN: begin
                  element_length_in = data_byte;
                  body_offset_in    = '0;
                  oui_match_in      = 1'b0;
                  if (element_id_ff == ID_SSID) begin
                     ssid_length_in      = '0;
                     flags_in[FLAG_SSID] = 1'b1;
                  end else if (element_id_ff == ID_RSN) begin
                     flags_in[FLAG_RSN] = 1'b1;
                  end
                  phase_in = (data_byte != '0) ? PH_BODY : PH_ID;
               end
               PH_BODY: begin
                  if (element_id_ff == ID_SSID) begin
                     if ({1'b0, body_offset_ff} < SsidLimit) begin
                        ssid_emit      = 1'b1;
                        ssid_length_in = offset_inc[5:0];
                     end
                  end else if (element_id_ff == ID_DSSS) begin
                     if (body_offset_ff == 8'd0) begin
                        channel_in          = data_byte;
                        flags_in[FLAG_CHAN] = 1'b1;
                     end
                  end else if (element_id_ff == ID_VENDOR) begin
                     if (body_offset_ff == 8'd0) begin
                        oui_match_in = data_byte == OUI_BYTE0;
                     end else if (body_offset_ff == 8'd1) begin
                        oui_match_in = oui_match_ff && (data_byte == OUI_BYTE1);
                     end else if (body_offset_ff == 8'd2) begin
                        oui_match_in = oui_match_ff && (data_byte == OUI_BYTE2);
                     end else if (body_offset_ff == 8'd3 && oui_match_ff &&
                                  data_byte == WPA_TYPE) begin
                        flags_in[FLAG_WPA] = 1'b1;
                     end
                  end
                  body_offset_in = offset_inc;
                  if (offset_inc >= element_length_ff) begin
                     phase_in = PH_ID;
                  end
               end
               PH_DONE: begin
               end
               default: begin
               end
            endcase
            bytes_left_in = bytes_left_ff - 12'd1;
            if (bytes_left_in == '0) begin
               phase_in  = PH_DONE;
               summ_emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      ssid_entry                    = '0;
      ssid_entry.kind               = KIND_CHAR;
      ssid_entry.last               = !summ_emit;
      ssid_entry.data.ssid_position = body_offset_ff[5:0];
      ssid_entry.data.ssid_char     = data_byte;

      summ_entry                     = '0;
      summ_entry.kind                = KIND_SUMMARY;
      summ_entry.last                = 1'b1;
      summ_entry.data.ssid_length    = ssid_length_in;
      summ_entry.data.channel_number = channel_in;
      summ_entry.data.channel_seen   = flags_in[FLAG_CHAN];
      summ_entry.data.ssid_seen      = flags_in[FLAG_SSID];
      summ_entry.data.rsn_seen       = flags_in[FLAG_RSN];
      summ_entry.data.wpa_seen       = flags_in[FLAG_WPA];

      push0    = ssid_emit ? ssid_entry : summ_entry;
      push1    = summ_entry;
      push_cnt = {1'b0, ssid_emit} + {1'b0, summ_emit};
   end

   assign wr_ptr_next1 = wr_ptr_ff + PtrBits'(1);
   assign wr_ptr_in    = wr_ptr_ff + PtrBits'(push_cnt);
   assign rd_ptr_in    = rd_ptr_ff + PtrBits'(rsp_xfer);
   assign count_in     = count_ff + (PtrBits+1)'(push_cnt) - (PtrBits+1)'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_mem[wr_ptr_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         queue_mem[wr_ptr_next1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff     <= '0;
         phase_ff          <= PH_DONE;
         element_id_ff     <= '0;
         element_length_ff <= '0;
         body_offset_ff    <= '0;
         oui_match_ff      <= 1'b0;
         ssid_length_ff    <= '0;
         channel_ff        <= '0;
         flags_ff          <= '0;
         wr_ptr_ff         <= '0;
         rd_ptr_ff         <= '0;
         count_ff          <= '0;
      end else begin
         bytes_left_ff     <= bytes_left_in;
         phase_ff          <= phase_in;
         element_id_ff     <= element_id_in;
         element_length_ff <= element_length_in;
         body_offset_ff    <= body_offset_in;
         oui_match_ff      <= oui_match_in;
         ssid_length_ff    <= ssid_length_in;
         channel_ff        <= channel_in;
         flags_ff          <= flags_in;
         wr_ptr_ff         <= wr_ptr_in;
         rd_ptr_ff         <= rd_ptr_in;
         count_ff          <= count_in;
      end
   end

   assign rsp_tdata = queue_mem[rd_ptr_ff].data;
   assign rsp_tuser = queue_mem[rd_ptr_ff].kind;
   assign rsp_tlast = queue_mem[rd_ptr_ff].last;

endmodule

FILE: design/wiep_checker.sv
// Port-level checker for the WLAN information element parser.
// Depends on wiep_pkg; bound to wlan_information_element_parser_unit below.
module wiep_checker
   import wiep_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("Result transfer withdrawn while stalled.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result payload changed while stalled.");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SUMMARY |->
         rsp_tlast && rsp_tdata[13:0] == 14'd0)
      else $error("Summary transfer is not the last of its run or has character bits.");

   a_char_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_CHAR |-> rsp_tdata[31:14] == 18'd0)
      else $error("Character transfer carries summary bits.");

endmodule

bind wlan_information_element_parser_unit wiep_checker u_wiep_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
